// File: rtl/bemd_pkg.sv
// Package for the bitmap edge mask dilation block.
// Field widths, register indexes, request codes, default sizes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package bemd_pkg;

  // Input and result field widths
  localparam int REQ_W  = 1;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 3;
  localparam int PIX_W  = 8;
  localparam int MASK_W = 8;
  localparam int XK_W   = COL_W + 3;   // pixel column of one bit of a byte

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD = 1'b0;
  localparam logic [REQ_W-1:0] REQ_READ = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int IMG_DIM_W  = 7;
  localparam int EDGE_W     = 4;
  localparam int EDGE_FIELD_MAX = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_WIDTH   = 2'd2;

  localparam logic [IMG_DIM_W-1:0] IMAGE_WIDTH_RST  = 7'd64;
  localparam logic [IMG_DIM_W-1:0] IMAGE_HEIGHT_RST = 7'd64;
  localparam logic [EDGE_W-1:0]    EDGE_WIDTH_RST   = 4'd1;

  // Default sizes of the row store and window
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_EDGE_DEF   = 15;

  // Controller -> datapath
  typedef struct packed {
    logic start;     // input beat accepted: latch item, write on load
    logic init;      // set up pointers and counters for a read scan
    logic row_rd;    // issue one row read of the window
    logic col_step;  // fold one column offset into the mask
    logic out_load;  // move finished mask into the output register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_is_read;  // offered input beat is a read
    logic in_image;    // latched read lies inside the image
    logic row_last;    // current row read is the last of the window
    logic col_last;    // current column step is the last one
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/bemd_in_if.sv
// Input channel of the bitmap edge mask dilation block: valid/ready and
// one request beat. Depends on bemd_pkg for field widths.
`default_nettype none

interface bemd_in_if;
  logic                        valid;
  logic                        ready;
  logic [bemd_pkg::REQ_W-1:0]  req_type;
  logic [bemd_pkg::ROW_W-1:0]  row;
  logic [bemd_pkg::COL_W-1:0]  col_byte;
  logic [bemd_pkg::PIX_W-1:0]  pixel_byte;

  modport source (output valid, output req_type, output row, output col_byte,
                  output pixel_byte, input ready);
  modport sink   (input valid, input req_type, input row, input col_byte,
                  input pixel_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/bemd_out_if.sv
// Result channel of the bitmap edge mask dilation block: valid/ready and
// one mask byte beat. Depends on bemd_pkg for field widths.
`default_nettype none

interface bemd_out_if;
  logic                        valid;
  logic                        ready;
  logic [bemd_pkg::MASK_W-1:0] mask_byte;

  modport source (output valid, output mask_byte, input ready);
  modport sink   (input valid, input mask_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/bemd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module bemd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

// File: rtl/bemd_ctrl.sv
// Controller of the bitmap edge mask dilation block: sequences accept,
// row scan, column scan and result hand-off. Depends on bemd_pkg.
`default_nettype none

module bemd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire bemd_pkg::dp_sts_t sts,
  output bemd_pkg::dp_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ROWS  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_COLS  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (sts.in_is_read) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.in_image) begin
          cmd.init  = 1'b1;
          state_nxt = S_ROWS;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ROWS: begin
        cmd.row_rd = 1'b1;
        if (sts.row_last) state_nxt = S_DRAIN;
      end
      // last row data returns from the store this cycle
      S_DRAIN: state_nxt = S_COLS;
      S_COLS: begin
        cmd.col_step = 1'b1;
        if (sts.col_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output beat holds until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

`default_nettype wire

// File: rtl/bemd_dp.sv
// Datapath of the bitmap edge mask dilation block: configuration registers,
// byte-lane row store, row and column scan pointers and mask accumulation.
// Depends on bemd_pkg and bemd_ram.
`default_nettype none

module bemd_dp #(
  parameter int MAX_WIDTH  = bemd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bemd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_EDGE   = bemd_pkg::MAX_EDGE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bemd_pkg::dp_cmd_t                 cmd,
  output bemd_pkg::dp_sts_t                      sts,
  input  wire logic [bemd_pkg::REQ_W-1:0]        in_req_type,
  input  wire logic [bemd_pkg::ROW_W-1:0]        in_row,
  input  wire logic [bemd_pkg::COL_W-1:0]        in_col_byte,
  input  wire logic [bemd_pkg::PIX_W-1:0]        in_pixel_byte,
  input  wire logic                              cfg_we,
  input  wire logic [bemd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bemd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic      [bemd_pkg::MASK_W-1:0]       out_mask_byte
);
  localparam int ROW_BYTES = (MAX_WIDTH + 7) / 8;
  localparam int RWID      = ROW_BYTES * 8;
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int YW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int LW        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int EMAX      = (MAX_EDGE < bemd_pkg::EDGE_FIELD_MAX) ?
                             MAX_EDGE : bemd_pkg::EDGE_FIELD_MAX;
  localparam int EW        = (EMAX > 0) ? $clog2(EMAX + 1) : 1;
  localparam int SPAN_MAX  = 2 * EMAX + 1;
  localparam int SW        = $clog2(SPAN_MAX + 1);
  localparam int CW0       = (SW > WW) ? SW : WW;
  localparam int CW        = (CW0 > HW) ? CW0 : HW;
  localparam int CX        = CW + 1;
  localparam int NB        = bemd_pkg::MASK_W;

  // Configuration registers
  logic [bemd_pkg::IMG_DIM_W-1:0] cfg_w_r, cfg_h_r;
  logic [bemd_pkg::EDGE_W-1:0]    cfg_e_r;

  // Latched item
  logic [bemd_pkg::REQ_W-1:0] req_r;
  logic [bemd_pkg::ROW_W-1:0] row_r;
  logic [bemd_pkg::COL_W-1:0] col_r;

  // Scan state
  logic [YW-1:0]     rptr_r, rd_addr_r;
  logic [CW-1:0]     rcnt_r, ccnt_r;
  logic              rd_pend_r;
  logic [MAX_WIDTH-1:0] colz_r;
  logic [NB-1:0]     pad_r, acc_r, out_r;
  logic [XW-1:0]     cptr_r [NB];

  // Effective (clamped) sizes
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [EW-1:0] e_eff;
  logic [SW-1:0] span;
  logic          full_row, full_col;
  logic [CW-1:0] n_row, n_col;
  logic [WW:0]   w_p7;
  logic [WW:0]   nbytes;
  logic          in_image;

  // Store access
  logic          lane_we_base;
  logic [NB-1:0] lane_q [ROW_BYTES];
  logic [RWID-1:0] row_word;
  logic [YW-1:0] ram_waddr;

  // Per-bit column values
  logic [bemd_pkg::XK_W-1:0] xk [NB];
  logic [NB-1:0]             x_in;
  logic [XW-1:0]             cstart [NB];
  logic [XW-1:0]             cnext [NB];
  logic [YW-1:0]             rstart, rnext;
  logic [NB-1:0]             mask;

  always_comb begin
    if (cfg_w_r == '0) w_eff = WW'(1);
    else if (32'(cfg_w_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_w_r);
    if (cfg_h_r == '0) h_eff = HW'(1);
    else if (32'(cfg_h_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg_h_r);
    if (32'(cfg_e_r) > EMAX) e_eff = EW'(EMAX);
    else e_eff = EW'(cfg_e_r);
  end

  // Window span, and whether it covers the whole torus in each direction
  assign span     = SW'({e_eff, 1'b1});
  assign full_row = CW'(span) >= CW'(h_eff);
  assign full_col = CW'(span) >= CW'(w_eff);
  assign n_row    = full_row ? CW'(h_eff) : CW'(span);
  assign n_col    = full_col ? CW'(w_eff) : CW'(span);
  assign w_p7     = (WW+1)'(w_eff) + (WW+1)'(7);
  assign nbytes   = w_p7 >> 3;
  assign in_image = (32'(row_r) < 32'(h_eff)) && (32'(col_r) < 32'(nbytes));

  // Row start: (row - e) mod h, one correction since span < h there
  always_comb begin
    logic [CX-1:0] r_e, e_e, h_e;
    r_e = CX'(row_r);
    e_e = CX'(e_eff);
    h_e = CX'(h_eff);
    if (full_row) rstart = '0;
    else if (r_e >= e_e) rstart = YW'(r_e - e_e);
    else rstart = YW'(r_e + h_e - e_e);
  end

  // Next row pointer, wrapping at the image height
  always_comb begin
    logic [HW-1:0] rinc;
    rinc  = HW'(rptr_r) + HW'(1);
    rnext = (rinc == h_eff) ? '0 : YW'(rinc);
  end

  // Per-bit column positions, start points and next pointers
  always_comb begin
    logic [CX-1:0] x_e, e_e, w_e;
    logic [WW-1:0] cinc;
    e_e = CX'(e_eff);
    w_e = CX'(w_eff);
    for (int k = 0; k < NB; k++) begin
      xk[k]   = {col_r, 3'(k)};
      x_in[k] = 32'(xk[k]) < 32'(w_eff);
      x_e     = CX'(xk[k]);
      if (full_col) cstart[k] = '0;
      else if (x_e >= e_e) cstart[k] = XW'(x_e - e_e);
      else cstart[k] = XW'(x_e + w_e - e_e);
      cinc     = WW'(cptr_r[k]) + WW'(1);
      cnext[k] = (cinc == w_eff) ? '0 : XW'(cinc);
    end
  end

  // Final mask: window result inside the image, stored bits as padding
  always_comb begin
    for (int k = 0; k < NB; k++) begin
      if (x_in[k]) mask[k] = acc_r[k];
      else if (32'(xk[k]) < MAX_WIDTH) mask[k] = pad_r[k];
      else mask[k] = 1'b0;
    end
  end

  // Row store: one RAM per byte lane so a whole row is read as one word
  assign lane_we_base = cmd.start && (in_req_type == bemd_pkg::REQ_LOAD) &&
                        (32'(in_row) < MAX_HEIGHT) &&
                        (32'(in_col_byte) < ROW_BYTES);
  assign ram_waddr    = YW'(in_row);

  for (genvar l = 0; l < ROW_BYTES; l++) begin : g_lane
    bemd_ram #(
      .WIDTH (NB),
      .DEPTH (MAX_HEIGHT)
    ) u_ram (
      .clk   (clk),
      .we    (lane_we_base && (LW'(in_col_byte) == LW'(l))),
      .waddr (ram_waddr),
      .wdata (in_pixel_byte),
      .raddr (rptr_r),
      .rdata (lane_q[l])
    );
    assign row_word[l*8 +: 8] = lane_q[l];
  end

  // Status
  assign sts.in_is_read = (in_req_type == bemd_pkg::REQ_READ);
  assign sts.in_image   = in_image;
  assign sts.row_last   = (rcnt_r == CW'(1));
  assign sts.col_last   = (ccnt_r == CW'(1));
  assign out_mask_byte  = out_r;

  // Control registers: configuration and read-pending flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= bemd_pkg::IMAGE_WIDTH_RST;
      cfg_h_r   <= bemd_pkg::IMAGE_HEIGHT_RST;
      cfg_e_r   <= bemd_pkg::EDGE_WIDTH_RST;
      rd_pend_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bemd_pkg::CFG_IMAGE_WIDTH:  cfg_w_r <= cfg_wdata;
          bemd_pkg::CFG_IMAGE_HEIGHT: cfg_h_r <= cfg_wdata;
          bemd_pkg::CFG_EDGE_WIDTH:   cfg_e_r <= cfg_wdata[bemd_pkg::EDGE_W-1:0];
          default: ;
        endcase
      end
      rd_pend_r <= cmd.row_rd;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= in_req_type;
      row_r <= in_row;
      col_r <= in_col_byte;
    end

    if (cmd.init) begin
      rptr_r <= rstart;
      rcnt_r <= n_row;
      ccnt_r <= n_col;
      colz_r <= '0;
      acc_r  <= '0;
      for (int k = 0; k < NB; k++) cptr_r[k] <= cstart[k];
    end else begin
      // row scan: issue next read
      if (cmd.row_rd) begin
        rptr_r    <= rnext;
        rd_addr_r <= rptr_r;
        rcnt_r    <= rcnt_r - CW'(1);
      end
      // returned row: mark columns holding a zero pixel
      if (rd_pend_r) begin
        colz_r <= colz_r | ~row_word[MAX_WIDTH-1:0];
        if (rd_addr_r == YW'(row_r)) pad_r <= lane_q[LW'(col_r)];
      end
      // column scan: one offset per cycle for all eight bits
      if (cmd.col_step) begin
        ccnt_r <= ccnt_r - CW'(1);
        for (int k = 0; k < NB; k++) begin
          if (x_in[k]) acc_r[k] <= acc_r[k] | colz_r[cptr_r[k]];
          cptr_r[k] <= cnext[k];
        end
      end
    end

    if (cmd.out_load) begin
      out_r <= (in_image && (req_r == bemd_pkg::REQ_READ)) ? mask : '0;
    end
  end
endmodule

`default_nettype wire

// File: rtl/bitmap_edge_mask_dilation.sv
// Cursor mask builder: dilates the zero pixels of a 1-bit bitmap over a
// square window of +/- edge_width, wrapping around the image as a torus.
// A load beat writes one packed byte into the row store. A read beat returns
// one mask byte after a scan of min(2e+1, h) rows and min(2e+1, w) column
// offsets (e, w, h the clamped edge width, image width and height): the row
// store gives one full row word per cycle, and the column pass folds one
// window offset per cycle into all eight mask bits. A read outside the image
// returns 0 without a scan. A new beat is taken while the previous result
// waits in the output register. The row store has no reset; the whole
// frame must be loaded before it is read. Configuration writes are taken
// whenever cfg_we is high and must only come while the block is idle.
`default_nettype none

module bitmap_edge_mask_dilation #(
  parameter int MAX_WIDTH  = bemd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bemd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_EDGE   = bemd_pkg::MAX_EDGE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bemd_in_if.sink                              in_bus,
  bemd_out_if.source                           out_bus,
  input  wire logic                            cfg_we,
  input  wire logic [bemd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bemd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  bemd_pkg::dp_cmd_t cmd;
  bemd_pkg::dp_sts_t sts;
  logic              in_ready;
  logic              out_valid;
  logic [bemd_pkg::MASK_W-1:0] mask_byte;

  assign in_bus.ready      = in_ready;
  assign out_bus.valid     = out_valid;
  assign out_bus.mask_byte = mask_byte;

  bemd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bemd_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_EDGE   (MAX_EDGE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_bus.req_type),
    .in_row        (in_bus.row),
    .in_col_byte   (in_bus.col_byte),
    .in_pixel_byte (in_bus.pixel_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_mask_byte (mask_byte)
  );

  // Commands never overlap
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.init, cmd.row_rd, cmd.col_step, cmd.out_load}))
    else $error("controller issued overlapping datapath commands");

  // Row scan stops after its last row
  a_row_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.row_rd && sts.row_last) |=> !cmd.row_rd)
    else $error("row scan ran past the window");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_bus.valid || out_bus.ready))
    else $error("result register loaded while holding an untaken beat");

  // A beat is only started on an input handshake
  a_start_hs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> (in_bus.valid && in_bus.ready))
    else $error("item started without an input handshake");
endmodule

`default_nettype wire

// File: test/tb_bitmap_edge_mask_dilation.sv
// Self-checking testbench for bitmap_edge_mask_dilation: directed table, then
// random frames of random size, mask bytes checked against a torus dilation.
// Depends on bemd_pkg, bemd_in_if, bemd_out_if and the block itself.
`timescale 1ns / 1ps

module tb_bitmap_edge_mask_dilation;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int ITEM_GOAL     = 850;
  localparam int IDLE_PCT      = 26;
  // no idling on either side inside this cycle window
  localparam int QUIET_FROM    = 3000;
  localparam int QUIET_TO      = 7000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 60;
  // a load may still be in flight after the last mask beat
  localparam int SETTLE_CYCLES = 70;
  // ~850 beats at the longest read each, stretched by both sides idling,
  // plus settle gaps per setting and the long hold, taken six times over
  localparam int LIMIT_CYCLES  = 600000;
  localparam int MAX_REPORTS   = 10;

  typedef logic [bemd_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [bemd_pkg::CFG_DATA_W-1:0] cfg_val_t;
  typedef logic [bemd_pkg::REQ_W-1:0]      req_t;
  typedef logic [bemd_pkg::ROW_W-1:0]      row_t;
  typedef logic [bemd_pkg::COL_W-1:0]      col_t;
  typedef logic [bemd_pkg::PIX_W-1:0]      pix_t;
  typedef logic [bemd_pkg::MASK_W-1:0]     mask_t;

  localparam cfg_idx_t CFG_NO_REG = 2'd3;

  // One row of the directed plan: a register write or an input beat
  typedef struct packed {
    logic     is_cfg;
    cfg_idx_t reg_idx;
    cfg_val_t reg_val;
    req_t     req;
    row_t     row;
    col_t     col;
    pix_t     pix;
    logic     fixed_exp;
    mask_t    mask;
  } plan_step_t;

  localparam int PLAN_ROWS = 32;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  cfg_val_t cfg_wdata;

  bemd_in_if  in_bus ();
  bemd_out_if out_bus ();

  bitmap_edge_mask_dilation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Shadow of the block: bitmap bytes and register values
  bit   [bemd_pkg::PIX_W-1:0] pix_store [bemd_pkg::MAX_HEIGHT_DEF][bemd_pkg::MAX_WIDTH_DEF/8];
  logic [bemd_pkg::IMG_DIM_W-1:0] cur_width;
  logic [bemd_pkg::IMG_DIM_W-1:0] cur_height;
  logic [bemd_pkg::EDGE_W-1:0]    cur_edge;

  mask_t pending_masks [$];
  mask_t want_mask;

  int cycle_count  = 0;
  int items_sent   = 0;
  int loads_sent   = 0;
  int reads_sent   = 0;
  int cfg_writes   = 0;
  int settings     = 0;
  int masks_seen   = 0;
  int fail_count   = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit mixing       = 1'b0;

  function automatic int eff_dim(logic [bemd_pkg::IMG_DIM_W-1:0] v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int torus(int v, int m);
    return ((v % m) + m) % m;
  endfunction

  // Mask byte for one read: 1 where a zero pixel lies in the wrapped window
  function automatic mask_t dilate_byte(int y, int cb);
    int w, h, e, nb, k, x, dx, dy, xx, yy;
    mask_t m;
    bit hit;
    w  = eff_dim(cur_width, bemd_pkg::MAX_WIDTH_DEF);
    h  = eff_dim(cur_height, bemd_pkg::MAX_HEIGHT_DEF);
    e  = cur_edge;
    nb = (w + 7) / 8;
    m  = '0;
    if (y >= h || cb >= nb) return '0;
    for (k = 0; k < 8; k++) begin
      x = cb * 8 + k;
      if (x >= w) begin
        // padding past the image edge comes straight from the stored byte
        m[k] = pix_store[y][cb][k];
      end else begin
        hit = 1'b0;
        for (dy = -e; dy <= e; dy++) begin
          yy = torus(y + dy, h);
          for (dx = -e; dx <= e; dx++) begin
            xx = torus(x + dx, w);
            if (!pix_store[yy][xx / 8][xx % 8]) hit = 1'b1;
          end
        end
        m[k] = hit;
      end
    end
    return m;
  endfunction

  function automatic bit roll_idle();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // Bitmap bytes lean toward mostly-set so masks do not saturate
  function automatic pix_t bitmap_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 8'hFF;
    if (pick < 7) return ~(8'h01 << $urandom_range(0, 7));
    return pix_t'($urandom);
  endfunction

  function automatic plan_step_t mk_cfg(cfg_idx_t i, cfg_val_t v);
    plan_step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.reg_idx = i;
    s.reg_val = v;
    return s;
  endfunction

  function automatic plan_step_t mk_beat(req_t req, row_t r, col_t c, pix_t p);
    plan_step_t s;
    s = '0;
    s.req = req;
    s.row = r;
    s.col = c;
    s.pix = p;
    return s;
  endfunction

  function automatic plan_step_t mk_read_is(row_t r, col_t c, mask_t m);
    plan_step_t s;
    s = mk_beat(bemd_pkg::REQ_READ, r, c, '0);
    s.fixed_exp = 1'b1;
    s.mask      = m;
    return s;
  endfunction

  // Directed plan; typed masks only where obvious
  function automatic plan_step_t plan_row(int n);
    case (n)
      0:  return mk_cfg(bemd_pkg::CFG_IMAGE_WIDTH, 7'd8);
      1:  return mk_cfg(bemd_pkg::CFG_IMAGE_HEIGHT, 7'd2);
      2:  return mk_beat(bemd_pkg::REQ_LOAD, 6'd0, 3'd0, 8'hFF);
      3:  return mk_beat(bemd_pkg::REQ_LOAD, 6'd1, 3'd0, 8'hFF);
      4:  return mk_read_is(6'd0, 3'd0, 8'h00);   // no zero pixel anywhere
      5:  return mk_read_is(6'd2, 3'd0, 8'h00);   // row past image height
      6:  return mk_read_is(6'd0, 3'd1, 8'h00);   // byte past image width
      7:  return mk_beat(bemd_pkg::REQ_LOAD, 6'd1, 3'd0, 8'hFE);
      8:  return mk_beat(bemd_pkg::REQ_READ, 6'd0, 3'd0, 8'h00);
      9:  return mk_beat(bemd_pkg::REQ_READ, 6'd1, 3'd0, 8'h00);
      10: return mk_cfg(bemd_pkg::CFG_EDGE_WIDTH, 7'd15);
      11: return mk_read_is(6'd0, 3'd0, 8'hFF);   // window wraps the whole frame
      12: return mk_cfg(bemd_pkg::CFG_EDGE_WIDTH, 7'd0);
      13: return mk_read_is(6'd1, 3'd0, 8'h01);   // zero window: mask = ~pixels
      14: return mk_cfg(bemd_pkg::CFG_IMAGE_WIDTH, 7'd1);
      15: return mk_cfg(bemd_pkg::CFG_IMAGE_HEIGHT, 7'd1);
      16: return mk_beat(bemd_pkg::REQ_LOAD, 6'd0, 3'd0, 8'hAB);
      17: return mk_read_is(6'd0, 3'd0, 8'hAA);   // padding bits pass through
      18: return mk_beat(bemd_pkg::REQ_LOAD, 6'd0, 3'd0, 8'h54);
      19: return mk_read_is(6'd0, 3'd0, 8'h55);
      20: return mk_read_is(6'd0, 3'd1, 8'h00);
      21: return mk_cfg(bemd_pkg::CFG_IMAGE_WIDTH, 7'd12);
      22: return mk_cfg(bemd_pkg::CFG_IMAGE_HEIGHT, 7'd3);
      23: return mk_cfg(bemd_pkg::CFG_EDGE_WIDTH, 7'd2);
      24: return mk_beat(bemd_pkg::REQ_LOAD, 6'd0, 3'd1, 8'hF0);
      25: return mk_beat(bemd_pkg::REQ_LOAD, 6'd1, 3'd1, 8'hFF);
      26: return mk_beat(bemd_pkg::REQ_LOAD, 6'd2, 3'd0, 8'h00);
      27: return mk_beat(bemd_pkg::REQ_LOAD, 6'd2, 3'd1, 8'h7F);
      28: return mk_beat(bemd_pkg::REQ_READ, 6'd0, 3'd1, 8'h00);
      29: return mk_beat(bemd_pkg::REQ_READ, 6'd2, 3'd0, 8'h00);
      30: return mk_beat(bemd_pkg::REQ_LOAD, 6'd63, 3'd7, 8'hFF); // outside image, still stored
      default: return mk_beat(bemd_pkg::REQ_READ, 6'd1, 3'd1, 8'h00);
    endcase
  endfunction

  // Register write, to be issued only while the block is idle; the task does not check it
  task automatic write_reg(cfg_idx_t idx, cfg_val_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      bemd_pkg::CFG_IMAGE_WIDTH:  cur_width  = val;
      bemd_pkg::CFG_IMAGE_HEIGHT: cur_height = val;
      bemd_pkg::CFG_EDGE_WIDTH:   cur_edge   = val[bemd_pkg::EDGE_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one input beat, hold it until taken, then predict its outcome
  task automatic send_beat(req_t req, row_t r, col_t c, pix_t p,
                           logic fixed_exp, mask_t fixed_mask);
    while (roll_idle()) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.req_type   <= req;
    in_bus.row        <= r;
    in_bus.col_byte   <= c;
    in_bus.pixel_byte <= p;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    if (req == bemd_pkg::REQ_LOAD) begin
      pix_store[r][c] = p;
      loads_sent++;
    end else begin
      pending_masks.push_back(fixed_exp ? fixed_mask : dilate_byte(r, c));
      reads_sent++;
    end
    @(negedge clk);
  endtask

  // Drop valid, let every pending mask come back, then let the block settle
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_masks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic flag(string what, mask_t want, mask_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s: expected 0x%02h got 0x%02h (cycle %0d)", what, want, got, cycle_count);
  endtask

  // Cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("cycle limit hit, %0d masks still pending", pending_masks.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random back-pressure plus one long hold-off mid-run
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (!hold_done && mixing && masks_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !roll_idle();
      end
    end
  end

  // Compare each mask beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      masks_seen++;
      if (pending_masks.size() == 0) begin
        flag("mask beat with no read pending", '0, out_bus.mask_byte);
      end else begin
        want_mask = pending_masks.pop_front();
        if (want_mask !== out_bus.mask_byte)
          flag("mask_byte mismatch", want_mask, out_bus.mask_byte);
      end
    end
  end

  // Stimulus
  initial begin
    plan_step_t s;
    int n, mode, pick, w, h, nb, y, c, mix_len;
    cfg_val_t wv, hv;
    logic [bemd_pkg::EDGE_W-1:0] ev;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.req_type   = bemd_pkg::REQ_LOAD;
    in_bus.row        = '0;
    in_bus.col_byte   = '0;
    in_bus.pixel_byte = '0;
    cur_width         = bemd_pkg::IMAGE_WIDTH_RST;
    cur_height        = bemd_pkg::IMAGE_HEIGHT_RST;
    cur_edge          = bemd_pkg::EDGE_WIDTH_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed plan
    for (n = 0; n < PLAN_ROWS; n++) begin
      s = plan_row(n);
      if (s.is_cfg) begin
        wait_idle();
        write_reg(s.reg_idx, s.reg_val);
      end else begin
        send_beat(s.req, s.row, s.col, s.pix, s.fixed_exp, s.mask);
      end
    end

    // Random settings: load a fresh frame, then mixed reads and loads
    while (items_sent < ITEM_GOAL) begin
      mixing = 1'b0;
      wait_idle();
      mode = $urandom_range(0, 15);
      case (mode)
        0: begin wv = 7'd64; hv = cfg_val_t'($urandom_range(1, 3)); end
        1: begin
          wv = cfg_val_t'($urandom_range(1, 8));
          hv = $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127));
        end
        2: begin wv = 7'd0; hv = 7'd0; end        // both clamp up to 1
        3: begin
          wv = cfg_val_t'($urandom_range(65, 127));
          hv = cfg_val_t'($urandom_range(1, 2));
        end
        4: begin wv = 7'd1; hv = cfg_val_t'($urandom_range(1, 8)); end
        default: begin
          wv = cfg_val_t'($urandom_range(1, 24));
          hv = cfg_val_t'($urandom_range(1, 6));
        end
      endcase
      pick = $urandom_range(0, 4);
      ev = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : 4'($urandom_range(0, 15));
      write_reg(bemd_pkg::CFG_IMAGE_WIDTH, wv);
      write_reg(bemd_pkg::CFG_IMAGE_HEIGHT, hv);
      // upper data bits on the edge register are junk and must be dropped
      write_reg(bemd_pkg::CFG_EDGE_WIDTH, {3'($urandom), ev});
      if ($urandom_range(0, 3) == 0) write_reg(CFG_NO_REG, cfg_val_t'($urandom));
      settings++;

      w  = eff_dim(cur_width, bemd_pkg::MAX_WIDTH_DEF);
      h  = eff_dim(cur_height, bemd_pkg::MAX_HEIGHT_DEF);
      nb = (w + 7) / 8;
      for (y = 0; y < h; y++)
        for (c = 0; c < nb; c++)
          send_beat(bemd_pkg::REQ_LOAD, row_t'(y), col_t'(c), bitmap_byte(), 1'b0, '0);

      mixing  = 1'b1;
      mix_len = $urandom_range(12, 30);
      repeat (mix_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 65)
          send_beat(bemd_pkg::REQ_READ, row_t'($urandom_range(0, h - 1)),
                    col_t'($urandom_range(0, nb - 1)), pix_t'($urandom), 1'b0, '0);
        else if (pick < 75)
          send_beat(bemd_pkg::REQ_READ, row_t'($urandom), col_t'($urandom),
                    pix_t'($urandom), 1'b0, '0);
        else if (pick < 90)
          send_beat(bemd_pkg::REQ_LOAD, row_t'($urandom_range(0, h - 1)),
                    col_t'($urandom_range(0, nb - 1)), bitmap_byte(), 1'b0, '0);
        else
          send_beat(bemd_pkg::REQ_LOAD, row_t'($urandom), col_t'($urandom),
                    pix_t'($urandom), 1'b0, '0);
      end
    end

    mixing = 1'b0;
    wait_idle();

    $display("run: %0d beats (%0d loads, %0d reads), %0d register writes, %0d random settings",
             items_sent, loads_sent, reads_sent, cfg_writes, settings);
    $display("run: %0d mask bytes compared, %0d failures", masks_seen, fail_count);
    if (fail_count == 0 && pending_masks.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
